/* rtl/sxl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sxl_pkg: shared types and constants of the s-expression token lexer
// Lexer modes, token kinds, result record layout and character classes.
// ----------------------------------------------------------------------------
package sxl_pkg;

    // lexer mode held between characters
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_STR   = 3'd1,
        MODE_SYM   = 3'd2,
        MODE_NUM   = 3'd3,
        MODE_PLUS  = 3'd4,
        MODE_MINUS = 3'd5
    } t_mode;

    // token kind codes on the result port
    typedef enum logic [3:0] {
        KIND_EOF      = 4'd0,
        KIND_STRING   = 4'd1,
        KIND_QUOTE    = 4'd2,
        KIND_LPAREN   = 4'd3,
        KIND_RPAREN   = 4'd4,
        KIND_STAR     = 4'd5,
        KIND_PLUS     = 4'd6,
        KIND_MINUS    = 4'd7,
        KIND_DOT      = 4'd8,
        KIND_SLASH    = 4'd9,
        KIND_NUMBER   = 4'd10,
        KIND_SYMBOL   = 4'd11,
        KIND_UNDEF    = 4'd12,
        KIND_UNCLOSED = 4'd13
    } t_kind;

    // one result record
    typedef struct packed {
        t_kind              kind;
        logic               carries;
        logic [7:0]         text;
        logic               done;
        logic signed [31:0] value;
        logic               last;
    } t_rec;

    // saturation limit of the number magnitude
    localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

    // result queue depth
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // punctuation characters
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // build a record with the last flag clear
    function automatic t_rec mk_rec(input t_kind k, input logic carries,
                                    input logic [7:0] text,
                                    input logic signed [31:0] value);
        t_rec r;
        r.kind    = k;
        r.carries = carries;
        r.text    = carries ? text : 8'd0;
        r.done    = ~carries;
        r.value   = value;
        r.last    = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/sxl_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sxl_step: lexer step logic
// Given the held mode, number magnitude and sign plus one input character,
// forms the next state and up to two result records.
// ----------------------------------------------------------------------------
module sxl_step (
    input  var sxl_pkg::t_mode i_mode,
    input  var logic [30:0]    i_accum,
    input  var logic           i_neg,
    input  var logic [7:0]     i_ch,
    input  var logic           i_eoi,
    output sxl_pkg::t_mode     o_mode,
    output logic [30:0]        o_accum,
    output logic               o_neg,
    output sxl_pkg::t_rec      o_rec0,
    output sxl_pkg::t_rec      o_rec1,
    output logic [1:0]         o_res_n
);
    import sxl_pkg::*;

    logic               close_v;
    t_rec               close_r;
    logic               idle_v;
    t_rec               idle_r;
    t_mode              idle_mode;
    logic [30:0]        idle_accum;
    logic               idle_neg;
    logic               a_v;
    t_rec               a_r;
    logic               b_v;
    t_rec               b_r;
    logic [34:0]        prod;
    logic signed [31:0] num_val;

    // signed value of the pending number
    assign num_val = i_neg ? -$signed({1'b0, i_accum}) : $signed({1'b0, i_accum});

    // accumulate one more decimal digit
    assign prod = ({4'd0, i_accum} << 3) + ({4'd0, i_accum} << 1) + {31'd0, i_ch[3:0]};

    // token that closes the pending number, symbol or sign
    always_comb begin
        close_v = 1'b1;
        close_r = mk_rec(KIND_SYMBOL, 1'b0, 8'd0, 32'sd0);
        case (i_mode)
            MODE_SYM:   close_r = mk_rec(KIND_SYMBOL, 1'b0, 8'd0, 32'sd0);
            MODE_PLUS:  close_r = mk_rec(KIND_PLUS, 1'b0, 8'd0, 32'sd0);
            MODE_MINUS: close_r = mk_rec(KIND_MINUS, 1'b0, 8'd0, 32'sd0);
            MODE_NUM:   close_r = mk_rec(KIND_NUMBER, 1'b0, 8'd0, num_val);
            default:    close_v = 1'b0;
        endcase
    end

    // character lexed from the idle mode
    always_comb begin
        idle_v     = 1'b1;
        idle_mode  = MODE_IDLE;
        idle_accum = 31'd0;
        idle_neg   = 1'b0;
        idle_r     = mk_rec(KIND_UNDEF, 1'b0, 8'd0, 32'sd0);
        if (is_space(i_ch)) begin
            idle_v = 1'b0;
        end else begin
            case (i_ch)
                CH_DQUOTE: begin
                    idle_v    = 1'b0;
                    idle_mode = MODE_STR;
                end
                CH_SQUOTE: idle_r = mk_rec(KIND_QUOTE, 1'b0, 8'd0, 32'sd0);
                CH_LPAREN: idle_r = mk_rec(KIND_LPAREN, 1'b0, 8'd0, 32'sd0);
                CH_RPAREN: idle_r = mk_rec(KIND_RPAREN, 1'b0, 8'd0, 32'sd0);
                CH_STAR:   idle_r = mk_rec(KIND_STAR, 1'b0, 8'd0, 32'sd0);
                CH_DOT:    idle_r = mk_rec(KIND_DOT, 1'b0, 8'd0, 32'sd0);
                CH_SLASH:  idle_r = mk_rec(KIND_SLASH, 1'b0, 8'd0, 32'sd0);
                CH_PLUS: begin
                    idle_v    = 1'b0;
                    idle_mode = MODE_PLUS;
                end
                CH_MINUS: begin
                    idle_v    = 1'b0;
                    idle_mode = MODE_MINUS;
                end
                default: begin
                    if (is_digit(i_ch)) begin
                        idle_v     = 1'b0;
                        idle_mode  = MODE_NUM;
                        idle_accum = {27'd0, i_ch[3:0]};
                    end else if (is_alpha(i_ch)) begin
                        idle_mode = MODE_SYM;
                        idle_r    = mk_rec(KIND_SYMBOL, 1'b1, i_ch, 32'sd0);
                    end
                end
            endcase
        end
    end

    // mode dispatch: records a then b, in output order
    always_comb begin
        o_mode  = i_mode;
        o_accum = i_accum;
        o_neg   = i_neg;
        a_v     = 1'b0;
        a_r     = close_r;
        b_v     = 1'b0;
        b_r     = idle_r;
        if (i_eoi) begin
            o_mode  = MODE_IDLE;
            o_accum = 31'd0;
            o_neg   = 1'b0;
            b_v     = 1'b1;
            if (i_mode == MODE_STR) begin
                b_r = mk_rec(KIND_UNCLOSED, 1'b0, 8'd0, 32'sd0);
            end else begin
                a_v = close_v;
                b_r = mk_rec(KIND_EOF, 1'b0, 8'd0, 32'sd0);
            end
        end else if (i_mode == MODE_STR) begin
            b_v = 1'b1;
            if (i_ch == CH_DQUOTE) begin
                o_mode = MODE_IDLE;
                b_r    = mk_rec(KIND_STRING, 1'b0, 8'd0, 32'sd0);
            end else begin
                b_r = mk_rec(KIND_STRING, 1'b1, i_ch, 32'sd0);
            end
        end else if (i_mode == MODE_SYM &&
                     (is_alpha(i_ch) || is_digit(i_ch) || i_ch == CH_MINUS)) begin
            b_v = 1'b1;
            b_r = mk_rec(KIND_SYMBOL, 1'b1, i_ch, 32'sd0);
        end else if (i_mode == MODE_NUM && is_digit(i_ch)) begin
            o_accum = (prod > {4'd0, MAG_MAX}) ? MAG_MAX : prod[30:0];
        end else if ((i_mode == MODE_PLUS || i_mode == MODE_MINUS) && is_digit(i_ch)) begin
            o_mode  = MODE_NUM;
            o_accum = {27'd0, i_ch[3:0]};
            o_neg   = (i_mode == MODE_MINUS);
        end else begin
            // close any pending token, then lex the character from idle
            a_v     = close_v;
            b_v     = idle_v;
            o_mode  = idle_mode;
            o_accum = idle_accum;
            o_neg   = idle_neg;
        end
    end

    // pack the records and flag the last one
    always_comb begin
        o_rec0  = a_v ? a_r : b_r;
        o_rec1  = b_r;
        o_res_n = {1'b0, a_v} + {1'b0, b_v};
        if (a_v && b_v) begin
            o_rec1.last = 1'b1;
        end else begin
            o_rec0.last = 1'b1;
        end
    end

endmodule
`default_nettype wire

/* rtl/sxl_res_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sxl_res_fifo: result record queue
// Small register queue that takes up to two records a cycle and gives one.
// ----------------------------------------------------------------------------
module sxl_res_fifo (
    input  var logic                    i_clk,
    input  var logic                    i_rst_n,
    input  var logic [1:0]              i_push_n,
    input  var sxl_pkg::t_rec           i_rec0,
    input  var sxl_pkg::t_rec           i_rec1,
    input  var logic                    i_pop,
    output sxl_pkg::t_rec               o_head,
    output logic [sxl_pkg::QCNT_W-1:0]  o_count
);
    import sxl_pkg::*;

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic [QPTR_W-1:0] wr_ptr1;

    assign wr_ptr1 = r_wr_ptr + QPTR_W'(1);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_push_n);
        n_rd_ptr = r_rd_ptr + QPTR_W'(i_pop);
        n_count  = r_count + QCNT_W'(i_push_n) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // record storage
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_rec0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_ptr1] <= i_rec1;
        end
    end

endmodule
`default_nettype wire

/* rtl/sexpr_token_lexer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sexpr_token_lexer_unit: s-expression tokenizer
// One character request per cycle, while the queue has room, into an input register; the step logic
// forms up to two token records that go into a four-entry result queue.
// ----------------------------------------------------------------------------
// An input request passes the input register and then the result queue to the outputs.
// Throughput: one character per cycle while each gives at most one result
// and results are taken; output is one record per cycle, set by the queue.
// Reset: synchronous active-low i_rst_n clears mode, number, input register
// and queue; the block is ready in the first cycle after reset.
module sexpr_token_lexer_unit (
    input  var logic               i_clk,
    input  var logic               i_rst_n,
    input  var logic               i_valid,
    output logic                   o_ready,
    input  var logic [7:0]         i_char_in,
    input  var logic               i_end_marker,
    output logic                   o_valid,
    input  var logic               i_ready,
    output logic [3:0]             o_token_kind,
    output logic                   o_carries_char,
    output logic [7:0]             o_text_char,
    output logic                   o_token_done,
    output logic signed [31:0]     o_number_value,
    output logic                   o_last_of_run
);
    import sxl_pkg::*;

    logic              r_in_valid;
    logic              n_in_valid;
    logic [7:0]        r_char;
    logic              r_end;
    t_mode             r_mode;
    t_mode             n_mode;
    logic [30:0]       r_accum;
    logic [30:0]       n_accum;
    logic              r_neg;
    logic              n_neg;
    t_rec              rec0;
    t_rec              rec1;
    logic [1:0]        n_res;
    logic              fire;
    logic              pop;
    logic [QCNT_W-1:0] q_count;
    t_rec              head;

    // lexer step on the registered character
    sxl_step u_step (
        .i_mode  (r_mode),
        .i_accum (r_accum),
        .i_neg   (r_neg),
        .i_ch    (r_char),
        .i_eoi   (r_end),
        .o_mode  (n_mode),
        .o_accum (n_accum),
        .o_neg   (n_neg),
        .o_rec0  (rec0),
        .o_rec1  (rec1),
        .o_res_n (n_res)
    );

    // step fires once the queue has room for all its records
    assign fire = r_in_valid &&
                  ({1'b0, q_count} + (QCNT_W + 1)'(n_res) <= (QCNT_W + 1)'(QDEPTH));
    assign o_ready = !r_in_valid || fire;
    assign pop     = o_valid && i_ready;

    sxl_res_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (fire ? n_res : 2'd0),
        .i_rec0   (rec0),
        .i_rec1   (rec1),
        .i_pop    (pop),
        .o_head   (head),
        .o_count  (q_count)
    );

    // input register control
    always_comb begin
        n_in_valid = r_in_valid;
        if (i_valid && o_ready) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_accum    <= 31'd0;
            r_neg      <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (fire) begin
                r_mode  <= n_mode;
                r_accum <= n_accum;
                r_neg   <= n_neg;
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char_in;
            r_end  <= i_end_marker;
        end
    end

    // result outputs from the queue head
    assign o_valid        = (q_count != '0);
    assign o_token_kind   = head.kind;
    assign o_carries_char = head.carries;
    assign o_text_char    = head.text;
    assign o_token_done   = head.done;
    assign o_number_value = head.value;
    assign o_last_of_run  = head.last;

endmodule
`default_nettype wire

/* rtl/sxl_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sxl_checker: port-level checks of the token lexer
// Watches the result channel and checks record consistency over time.
// ----------------------------------------------------------------------------
module sxl_checker (
    input  var logic               i_clk,
    input  var logic               i_rst_n,
    input  var logic               i_valid,
    input  var logic               o_ready,
    input  var logic               o_valid,
    input  var logic               i_ready,
    input  var logic [3:0]         o_token_kind,
    input  var logic               o_carries_char,
    input  var logic [7:0]         o_text_char,
    input  var logic               o_token_done,
    input  var logic signed [31:0] o_number_value,
    input  var logic               o_last_of_run
);
    import sxl_pkg::*;

    // a stalled result request holds its kind, text, value and last flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_kind) &&
        $stable(o_text_char) && $stable(o_number_value) && $stable(o_last_of_run))
        else $error("result changed while stalled");

    // a character record is never a token end and is always of the string
    // or symbol kind
    a_char_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_carries_char |-> !o_token_done &&
        (o_token_kind == KIND_STRING || o_token_kind == KIND_SYMBOL))
        else $error("character record with wrong kind or done flag");

    // only number tokens carry a value
    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind != KIND_NUMBER |-> o_number_value == 32'sd0)
        else $error("value on a non-number token");

    // a taken record that is not last of its run is followed by another
    // result pending in the next cycle (the pair is queued together)
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_run |=> o_valid)
        else $error("second record of a pair missing");

    // the input side is never ready without a free slot or an idle register:
    // after reset the block takes a request
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready || !i_rst_n)
        else $error("not ready after reset");

endmodule

bind sexpr_token_lexer_unit sxl_checker u_sxl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_token_kind   (o_token_kind),
    .o_carries_char (o_carries_char),
    .o_text_char    (o_text_char),
    .o_token_done   (o_token_done),
    .o_number_value (o_number_value),
    .o_last_of_run  (o_last_of_run)
);
`default_nettype wire
